/* hdl/prbd_pkg.sv */
`default_nettype none

package prbd_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_READ   = 2'd2,
    MODE_EMPTY  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] offset;
    logic [7:0]  data_byte;
    logic [12:0] count;
  } prbd_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       overflow;
    logic [2:0] fill_slot;
  } prbd_res_t;

  // slot table port controls
  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } tbl_ctl_t;

endpackage

`default_nettype wire

/* hdl/prbd_slot_table.sv */
`default_nettype none

module prbd_slot_table
  import prbd_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int LW    = 13,
  parameter int PW    = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tbl_ctl_t                   ctl,
  input  wire logic [$clog2(SLOTS)-1:0]   rd_slot,
  input  wire logic [$clog2(SLOTS)-1:0]   wr_slot,
  input  wire logic [LW-1:0]              wr_len,
  input  wire logic [PW-1:0]              wr_pos,
  output logic      [LW-1:0]              rd_len,
  output logic      [PW-1:0]              rd_pos
);

  logic [LW+PW-1:0] mem [SLOTS];
  logic [LW+PW-1:0] rd_q;
  logic [SLOTS-1:0] valid;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_slot] <= {wr_len, wr_pos};
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_slot];
    end
  end

  // an entry that is not valid reads as an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.wr) begin
        valid[wr_slot] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_valid <= valid[rd_slot];
      end
    end
  end

  assign rd_len = rd_valid ? rd_q[LW+PW-1:PW] : '0;
  assign rd_pos = rd_valid ? rd_q[PW-1:0] : '0;

endmodule

`default_nettype wire

/* hdl/prbd_byte_ram.sv */
`default_nettype none

module prbd_byte_ram
  import prbd_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]        wr_slot,
  input  wire logic [$clog2(SLOT_BYTES)-1:0]   wr_off,
  input  wire logic [7:0]                      wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]        rd_slot,
  input  wire logic [$clog2(SLOT_BYTES)-1:0]   rd_off,
  output logic      [7:0]                      rd_data
);

  localparam int DEPTH = SLOTS * SLOT_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // slot base is a multiply by a constant
  assign wr_addr = AW'(wr_slot) * AW'(SLOT_BYTES) + AW'(wr_off);
  assign rd_addr = AW'(rd_slot) * AW'(SLOT_BYTES) + AW'(rd_off);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/packet_ring_byte_drain_unit.sv */
// channel  | handshake       | payload     | notes
// request  | start / busy    | req         | taken when start is high and busy is low
// result   | done            | res         | one per request, valid for one cycle
//
// write, commit and empty requests do not raise busy; the result follows in the next cycle,
// so one of these can be taken every cycle while no read is in flight.
// a read goes through slot table read, then byte store read, then result;
// busy is high in ST_TBL and ST_BYTE, after the read request is taken.
// a read of an empty ring skips the byte store: busy is high only in ST_TBL, result next.
// rst is synchronous; it clears the indices, the overflow flag and the slot valid bits.
// the byte store is not cleared. the receiver cannot stall, so done never waits.
`default_nettype none

module packet_ring_byte_drain_unit
  import prbd_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire prbd_req_t req,
  output logic           done,
  output prbd_res_t      res
);

  localparam int FW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam int PW = $clog2(SLOT_BYTES);
  localparam int OW = (LW > 12) ? LW : 12;
  localparam int CW = (LW > 13) ? LW : 13;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TBL  = 3'b010,
    ST_BYTE = 3'b100
  } state_t;

  state_t        state;
  logic [FW-1:0] fill_index;
  logic [FW-1:0] drain_index;
  logic          ovf_flag;

  logic          accept;
  logic [OW-1:0] offset_x;
  logic          off_ok;
  logic [CW-1:0] count_x;
  logic [LW-1:0] cnt_sat;
  logic [FW-1:0] fill_adv;
  logic          commit_hit;

  tbl_ctl_t      tbl_ctl;
  logic [FW-1:0] tbl_wr_slot;
  logic [LW-1:0] tbl_wr_len;
  logic [PW-1:0] tbl_wr_pos;
  logic [LW-1:0] rd_len;
  logic [PW-1:0] rd_pos;

  logic          byte_wr;
  logic          byte_rd;
  logic [7:0]    byte_q;

  function automatic logic [FW-1:0] next_slot(input logic [FW-1:0] s);
    return (s == FW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [2:0] to_slot3(input logic [FW-1:0] s);
    logic [FW+2:0] e;
    e = {3'b000, s};
    return e[2:0];
  endfunction

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;

  assign offset_x = OW'(req.offset);
  assign off_ok   = (offset_x < OW'(SLOT_BYTES));
  assign count_x  = CW'(req.count);
  assign cnt_sat  = (count_x > CW'(SLOT_BYTES)) ? LW'(SLOT_BYTES) : count_x[LW-1:0];

  assign fill_adv   = next_slot(fill_index);
  assign commit_hit = (cnt_sat != '0) && (fill_adv == drain_index);

  // commit writes the fill slot; a read writes back the drain slot
  always_comb begin
    tbl_ctl.rd    = accept && (req.mode == MODE_READ);
    tbl_ctl.clear = accept && (req.mode == MODE_EMPTY);
    tbl_ctl.wr    = (accept && (req.mode == MODE_COMMIT)) ||
                    ((state == ST_TBL) && (rd_len != '0));
    if (state == ST_TBL) begin
      tbl_wr_slot = drain_index;
      tbl_wr_len  = rd_len - 1'b1;
      tbl_wr_pos  = rd_pos + 1'b1;
    end else begin
      tbl_wr_slot = fill_index;
      tbl_wr_len  = cnt_sat;
      tbl_wr_pos  = '0;
    end
  end

  assign byte_wr = accept && (req.mode == MODE_WRITE) && off_ok;
  assign byte_rd = (state == ST_TBL) && (rd_len != '0);

  prbd_slot_table #(
    .SLOTS (SLOTS),
    .LW    (LW),
    .PW    (PW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl_ctl),
    .rd_slot (drain_index),
    .wr_slot (tbl_wr_slot),
    .wr_len  (tbl_wr_len),
    .wr_pos  (tbl_wr_pos),
    .rd_len  (rd_len),
    .rd_pos  (rd_pos)
  );

  prbd_byte_ram #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_bytes (
    .clk     (clk),
    .wr_en   (byte_wr),
    .wr_slot (fill_index),
    .wr_off  (offset_x[PW-1:0]),
    .wr_data (req.data_byte),
    .rd_en   (byte_rd),
    .rd_slot (drain_index),
    .rd_off  (rd_pos),
    .rd_data (byte_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_index  <= '0;
      drain_index <= '0;
      ovf_flag    <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res.read_data  <= 8'd0;
            res.read_valid <= 1'b0;
            res.overflow   <= ovf_flag;
            res.fill_slot  <= to_slot3(fill_index);
            case (req.mode)
              MODE_WRITE: begin
                done <= 1'b1;
              end
              MODE_COMMIT: begin
                done <= 1'b1;
                if (cnt_sat != '0) begin
                  fill_index    <= fill_adv;
                  res.fill_slot <= to_slot3(fill_adv);
                end
                if (commit_hit) begin
                  ovf_flag     <= 1'b1;
                  res.overflow <= 1'b1;
                end
              end
              MODE_READ: begin
                state <= ST_TBL;
              end
              MODE_EMPTY: begin
                done          <= 1'b1;
                fill_index    <= '0;
                drain_index   <= '0;
                res.fill_slot <= 3'd0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_TBL: begin
          if (rd_len == '0) begin
            // empty ring: report the flag, then clear it
            ovf_flag <= 1'b0;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            if (rd_len == LW'(1)) begin
              drain_index <= next_slot(drain_index);
            end
            state <= ST_BYTE;
          end
        end
        ST_BYTE: begin
          res.read_data  <= byte_q;
          res.read_valid <= 1'b1;
          done           <= 1'b1;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_quick_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode != MODE_READ)) |=> done)
    else $error("write, commit or empty request gave no result");

  a_tbl_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TBL) |=> ((state == ST_IDLE) && done) || (state == ST_BYTE))
    else $error("slot table step went wrong");

  a_byte_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BYTE) |=> (done && res.read_valid && (state == ST_IDLE)))
    else $error("byte read gave no valid result");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    (done && res.read_valid) |-> $past(state == ST_BYTE))
    else $error("read_valid without a byte store read");

  a_no_done_mid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BYTE) |-> !done)
    else $error("result strobe while a read is in flight");
`endif

endmodule

`default_nettype wire

/* tb/packet_ring_byte_drain_unit_tb.sv */
`timescale 1ns / 100ps

module packet_ring_byte_drain_unit_tb;
  import prbd_pkg::*;

  localparam int SLOTS      = 8;
  localparam int SLOT_BYTES = 4096;
  localparam int STORE_SIZE = SLOTS * SLOT_BYTES;
  localparam int N_ITEMS    = 1950;
  // two copies of the ring: one steers stimulus generation, one predicts the dut
  localparam int PLAN  = 0;
  localparam int CHECK = 1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  prbd_req_t req = '0;
  logic      done;
  prbd_res_t res;

  packet_ring_byte_drain_unit #(
    .SLOTS(SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .res(res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  ring_bytes [2][STORE_SIZE];
  logic [12:0] slot_len [2][SLOTS];
  logic [11:0] slot_pos [2][SLOTS];
  logic [2:0]  drain_ix [2];
  logic [2:0]  fill_ix [2];
  logic        ovf_flag [2];
  bit          written [STORE_SIZE];

  prbd_req_t pending [$];
  prbd_res_t ring_results [$];

  int n_total = 0;
  int n_accepted = 0;
  int errors = 0;
  int n_writes = 0;
  int n_commits = 0;
  int n_clears = 0;
  int n_bytes_read = 0;
  int n_empty_reads = 0;
  int n_ovf_seen = 0;
  int burst_left = 1;
  int gap_left = 0;

  function automatic logic [2:0] next_slot(logic [2:0] s);
    return (int'(s) == SLOTS - 1) ? 3'd0 : s + 3'd1;
  endfunction

  function automatic void empty_ring(int w);
    for (int i = 0; i < SLOTS; i++) begin
      slot_len[w][i] = '0;
      slot_pos[w][i] = '0;
    end
    drain_ix[w] = '0;
    fill_ix[w] = '0;
  endfunction

  function automatic prbd_res_t ring_step(int w, prbd_req_t r);
    prbd_res_t o;
    logic [12:0] n;
    logic [2:0] d;
    o = '0;
    o.overflow = ovf_flag[w];
    case (r.mode)
      MODE_WRITE: begin
        if (int'(r.offset) < SLOT_BYTES)
          ring_bytes[w][int'(fill_ix[w]) * SLOT_BYTES + int'(r.offset)] = r.data_byte;
      end
      MODE_COMMIT: begin
        n = (int'(r.count) > SLOT_BYTES) ? 13'(SLOT_BYTES) : r.count;
        slot_len[w][fill_ix[w]] = n;
        slot_pos[w][fill_ix[w]] = '0;
        if (n != 0) begin
          fill_ix[w] = next_slot(fill_ix[w]);
          if (fill_ix[w] == drain_ix[w]) ovf_flag[w] = 1'b1;
        end
        o.overflow = ovf_flag[w];
      end
      MODE_READ: begin
        d = drain_ix[w];
        if (slot_len[w][d] == 0) begin
          ovf_flag[w] = 1'b0;
        end else begin
          o.read_data = ring_bytes[w][int'(d) * SLOT_BYTES + int'(slot_pos[w][d])];
          o.read_valid = 1'b1;
          slot_pos[w][d] = slot_pos[w][d] + 12'd1;
          slot_len[w][d] = slot_len[w][d] - 13'd1;
          if (slot_len[w][d] == 0) drain_ix[w] = next_slot(d);
        end
      end
      default: empty_ring(w);
    endcase
    o.fill_slot = fill_ix[w];
    return o;
  endfunction

  // a negative field argument means random; a read that would hit a byte
  // never written is turned into an empty command
  task automatic add(mode_t m, int off = -1, int dat = -1, int cnt = -1);
    prbd_req_t r;
    int d;
    r.mode = m;
    r.offset = (off < 0) ? 12'($urandom) : 12'(off);
    r.data_byte = (dat < 0) ? 8'($urandom) : 8'(dat);
    r.count = (cnt < 0) ? 13'($urandom) : 13'(cnt);
    d = int'(drain_ix[PLAN]);
    if (r.mode == MODE_READ && slot_len[PLAN][d] != 0 &&
        !written[d * SLOT_BYTES + int'(slot_pos[PLAN][d])])
      r.mode = MODE_EMPTY;
    if (r.mode == MODE_WRITE && int'(r.offset) < SLOT_BYTES)
      written[int'(fill_ix[PLAN]) * SLOT_BYTES + int'(r.offset)] = 1'b1;
    void'(ring_step(PLAN, r));
    pending.push_back(r);
  endtask

  task automatic compare(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    prbd_res_t p;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        p = ring_step(CHECK, req);
        ring_results.push_back(p);
        n_accepted++;
        case (req.mode)
          MODE_WRITE:  n_writes++;
          MODE_COMMIT: n_commits++;
          MODE_READ:   if (p.read_valid) n_bytes_read++; else n_empty_reads++;
          default:     n_clears++;
        endcase
        if (p.overflow) n_ovf_seen++;
      end
      if (start && busy) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        req <= pending.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    prbd_res_t want;
    if (!rst && done) begin
      if (ring_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %p", $time, res);
      end else begin
        want = ring_results.pop_front();
        compare("read_data", want.read_data, res.read_data);
        compare("read_valid", 8'(want.read_valid), 8'(res.read_valid));
        compare("overflow", 8'(want.overflow), 8'(res.overflow));
        compare("fill_slot", 8'(want.fill_slot), 8'(res.fill_slot));
      end
    end
  end

  initial begin
    int pick;
    int n;
    int k;
    int c;
    int cnt;
    for (int w = 0; w < 2; w++) begin
      for (int i = 0; i < STORE_SIZE; i++) ring_bytes[w][i] = '0;
      empty_ring(w);
      ovf_flag[w] = 1'b0;
    end

    // directed part
    add(MODE_READ);
    add(MODE_WRITE, 0, 8'h00);
    add(MODE_WRITE, 1, 8'hff);
    add(MODE_WRITE, 4095, 8'ha5);
    add(MODE_COMMIT, -1, -1, 2);
    add(MODE_READ);
    add(MODE_READ);
    add(MODE_READ);
    add(MODE_COMMIT, -1, -1, 0);
    add(MODE_WRITE, 0, 8'h5a);
    add(MODE_COMMIT, -1, -1, 8191);
    add(MODE_READ);
    add(MODE_EMPTY);
    for (int i = 0; i < SLOTS; i++) add(MODE_COMMIT, -1, -1, 1);
    // overrun lands in the drain slot
    add(MODE_COMMIT, -1, -1, 4096);
    add(MODE_READ);
    add(MODE_EMPTY);
    add(MODE_READ);
    add(MODE_READ);

    while (pending.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add(MODE_WRITE, i);
        c = $urandom_range(0, 19);
        if (c == 0) cnt = 0;
        else if (c < 4) cnt = $urandom_range(1, n);
        else if (c == 4) cnt = $urandom_range(SLOT_BYTES, 8191);
        else cnt = n;
        add(MODE_COMMIT, -1, -1, cnt);
      end else if (pick < 80) begin
        k = $urandom_range(1, 24);
        for (int i = 0; i < k; i++) add(MODE_READ);
      end else if (pick < 92) begin
        add(mode_t'($urandom_range(0, 2)));
      end else if (pick < 95) begin
        add(MODE_EMPTY);
      end else begin
        k = $urandom_range(1, SLOTS + 1);
        for (int i = 0; i < k; i++) add(MODE_COMMIT, -1, -1, $urandom_range(0, 3));
      end
    end
    n_total = pending.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || ring_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d requests: %0d byte writes, %0d commits, %0d ring clears", n_total,
             n_writes, n_commits, n_clears);
    $display("%0d bytes drained, %0d reads of an empty ring, overflow reported %0d times",
             n_bytes_read, n_empty_reads, n_ovf_seen);
    if (errors == 0) begin
      $display("packet_ring_byte_drain_unit_tb OK");
    end else begin
      $display("packet_ring_byte_drain_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d of %0d requests taken", n_accepted, n_total);
    $display("packet_ring_byte_drain_unit_tb NOT OK");
    $finish;
  end

endmodule

/* packet_ring_byte_drain_unit.f */
hdl/prbd_pkg.sv
hdl/prbd_slot_table.sv
hdl/prbd_byte_ram.sv
hdl/packet_ring_byte_drain_unit.sv
tb/packet_ring_byte_drain_unit_tb.sv
